FILE: rtl/cpu8_ld_pkg.sv
// shared types and constants for the 8-bit load unit
`timescale 1ns / 1ps

package cpu8_ld_pkg;

   // register file geometry
   localparam int REG_COUNT = 8;
   localparam int REG_IDX_W = $clog2(REG_COUNT);

   typedef logic [REG_IDX_W-1:0] reg_idx_type;
   typedef logic [7:0]           byte_type;
   typedef logic [15:0]          addr_type;
   typedef logic [4:0]           cycles_type;

   // register indexes
   localparam reg_idx_type REG_B = 3'd0;
   localparam reg_idx_type REG_C = 3'd1;
   localparam reg_idx_type REG_D = 3'd2;
   localparam reg_idx_type REG_E = 3'd3;
   localparam reg_idx_type REG_H = 3'd4;
   localparam reg_idx_type REG_L = 3'd5;
   localparam reg_idx_type REG_A = 3'd7;

   localparam byte_type HIGH_PAGE = 8'hff;

   // instruction cycle costs
   localparam cycles_type CYCLES_NONE = 5'd0;
   localparam cycles_type CYCLES_4    = 5'd4;
   localparam cycles_type CYCLES_8    = 5'd8;
   localparam cycles_type CYCLES_12   = 5'd12;
   localparam cycles_type CYCLES_16   = 5'd16;

   // queue geometry, same for the decoded op queue and the response queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef logic [QUEUE_PTR_W-1:0] queue_ptr_type;
   typedef logic [QUEUE_CNT_W-1:0] queue_cnt_type;

   localparam queue_ptr_type QUEUE_LAST = queue_ptr_type'(QUEUE_DEPTH - 1);
   localparam queue_cnt_type QUEUE_FULL = queue_cnt_type'(QUEUE_DEPTH);

   // what the back end does with an op
   typedef enum logic [2:0] {
      OP_NONE,
      OP_REG_WRITE,
      OP_READ,
      OP_WRITE,
      OP_RETURN
   } op_kind_type;

   // bus address source
   typedef enum logic [2:0] {
      ADDR_HL,
      ADDR_BC,
      ADDR_DE,
      ADDR_HIGH_C,
      ADDR_HIGH_N,
      ADDR_NN
   } addr_sel_type;

   // hl post adjust
   typedef enum logic [1:0] {
      HL_KEEP,
      HL_INC,
      HL_DEC
   } hl_adj_type;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_BUSY,
      STATUS_STRAY
   } status_type;

   // decoded op handed from front to back
   typedef struct packed {
      op_kind_type  kind;
      addr_sel_type addr_sel;
      hl_adj_type   hl_adj;
      logic         use_imm;
      reg_idx_type  reg_sel;
      reg_idx_type  dest;
      cycles_type   cycles;
      addr_type     imm;
      byte_type     read_data;
   } op_type;

   // one response
   typedef struct packed {
      logic        bus_valid;
      logic        bus_write;
      addr_type    bus_address;
      byte_type    bus_write_data;
      cycles_type  cycle_count;
      logic        reg_write_valid;
      reg_idx_type reg_write_index;
      byte_type    reg_write_value;
      status_type  status;
   } rsp_type;

endpackage

FILE: rtl/cpu_8bit_load_unit.sv
// top level of the 8-bit load unit
//
//   channel    ports          handshake                 payload
//   request    req_*          push / full               cmd, regs, immediate, read data
//   response   rsp_*          empty / pop               bus request, cycles, reg write, status
//
// one request per clock sustained while neither queue is full; a request's
// response is on the rsp ports once it has been written into the decode queue
// and then executed into the response queue, both of which are registered.
// the execute stage reads and writes the register file in the same cycle, which
// sets the rate. reset clears the register file, the pending read and both
// queues. a full response queue stalls execute, and the two-entry decode
// queue then fills before full is raised to the requester.
`timescale 1ns / 1ps

module cpu_8bit_load_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [4:0]  req_cmd,
   input  logic [2:0]  req_dest_reg,
   input  logic [2:0]  req_source_reg,
   input  logic [15:0] req_immediate,
   input  logic [7:0]  req_read_data,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_bus_valid,
   output logic        rsp_bus_write,
   output logic [15:0] rsp_bus_address,
   output logic [7:0]  rsp_bus_write_data,
   output logic [4:0]  rsp_cycle_count,
   output logic        rsp_reg_write_valid,
   output logic [2:0]  rsp_reg_write_index,
   output logic [7:0]  rsp_reg_write_value,
   output logic [1:0]  rsp_status
);
   import cpu8_ld_pkg::*;

   logic    op_valid;
   logic    op_ready;
   op_type  op;
   rsp_type rsp;

   // decode and queue
   cpu8_ld_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_cmd        (req_cmd),
      .req_dest_reg   (req_dest_reg),
      .req_source_reg (req_source_reg),
      .req_immediate  (req_immediate),
      .req_read_data  (req_read_data),
      .op_valid       (op_valid),
      .op             (op),
      .op_ready       (op_ready)
   );

   // execute and respond
   cpu8_ld_back u_back (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (op_valid),
      .op        (op),
      .op_ready  (op_ready),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp       (rsp)
   );

   // response fields
   assign rsp_bus_valid       = rsp.bus_valid;
   assign rsp_bus_write       = rsp.bus_write;
   assign rsp_bus_address     = rsp.bus_address;
   assign rsp_bus_write_data  = rsp.bus_write_data;
   assign rsp_cycle_count     = rsp.cycle_count;
   assign rsp_reg_write_valid = rsp.reg_write_valid;
   assign rsp_reg_write_index = rsp.reg_write_index;
   assign rsp_reg_write_value = rsp.reg_write_value;
   assign rsp_status          = rsp.status;

endmodule

FILE: rtl/cpu8_ld_front.sv
// front end: classifies load requests and queues the decoded ops
`timescale 1ns / 1ps

module cpu8_ld_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [4:0]           req_cmd,
   input  cpu8_ld_pkg::reg_idx_type req_dest_reg,
   input  cpu8_ld_pkg::reg_idx_type req_source_reg,
   input  logic [15:0]          req_immediate,
   input  logic [7:0]           req_read_data,
   output logic                 op_valid,
   output cpu8_ld_pkg::op_type  op,
   input  logic                 op_ready
);
   import cpu8_ld_pkg::*;

   // command codes
   localparam logic [4:0] CMD_LD_R_R      = 5'd0;
   localparam logic [4:0] CMD_LD_R_N      = 5'd1;
   localparam logic [4:0] CMD_LD_R_HL     = 5'd2;
   localparam logic [4:0] CMD_LD_HL_R     = 5'd3;
   localparam logic [4:0] CMD_LD_HL_N     = 5'd4;
   localparam logic [4:0] CMD_LD_A_BC     = 5'd5;
   localparam logic [4:0] CMD_LD_A_DE     = 5'd6;
   localparam logic [4:0] CMD_LD_A_HC     = 5'd7;
   localparam logic [4:0] CMD_LD_HC_A     = 5'd8;
   localparam logic [4:0] CMD_LD_A_HN     = 5'd9;
   localparam logic [4:0] CMD_LD_HN_A     = 5'd10;
   localparam logic [4:0] CMD_LD_A_NN     = 5'd11;
   localparam logic [4:0] CMD_LD_NN_A     = 5'd12;
   localparam logic [4:0] CMD_LD_A_HL_INC = 5'd13;
   localparam logic [4:0] CMD_LD_A_HL_DEC = 5'd14;
   localparam logic [4:0] CMD_LD_BC_A     = 5'd15;
   localparam logic [4:0] CMD_LD_DE_A     = 5'd16;
   localparam logic [4:0] CMD_LD_HL_INC_A = 5'd17;
   localparam logic [4:0] CMD_LD_HL_DEC_A = 5'd18;
   localparam logic [4:0] CMD_RETURN      = 5'd19;
   localparam logic [4:0] CMD_PRESET      = 5'd20;

   op_type        dec;
   op_type        queue_ff [QUEUE_DEPTH];
   queue_ptr_type wr_ptr_ff, wr_ptr_in;
   queue_ptr_type rd_ptr_ff, rd_ptr_in;
   queue_cnt_type count_ff, count_in;
   logic          push;
   logic          pop;

   // decode the command into kind, address source, data source and cost
   always_comb begin
      dec.kind      = OP_NONE;
      dec.addr_sel  = ADDR_HL;
      dec.hl_adj    = HL_KEEP;
      dec.use_imm   = 1'b0;
      dec.reg_sel   = REG_A;
      dec.dest      = REG_A;
      dec.cycles    = CYCLES_NONE;
      dec.imm       = req_immediate;
      dec.read_data = req_read_data;
      case (req_cmd)
         CMD_LD_R_R: begin
            dec.kind    = OP_REG_WRITE;
            dec.reg_sel = req_source_reg;
            dec.dest    = req_dest_reg;
            dec.cycles  = CYCLES_4;
         end
         CMD_LD_R_N: begin
            dec.kind    = OP_REG_WRITE;
            dec.use_imm = 1'b1;
            dec.dest    = req_dest_reg;
            dec.cycles  = CYCLES_8;
         end
         CMD_LD_R_HL: begin
            dec.kind   = OP_READ;
            dec.dest   = req_dest_reg;
            dec.cycles = CYCLES_8;
         end
         CMD_LD_HL_R: begin
            dec.kind    = OP_WRITE;
            dec.reg_sel = req_source_reg;
            dec.cycles  = CYCLES_8;
         end
         CMD_LD_HL_N: begin
            dec.kind    = OP_WRITE;
            dec.use_imm = 1'b1;
            dec.cycles  = CYCLES_12;
         end
         CMD_LD_A_BC: begin
            dec.kind     = OP_READ;
            dec.addr_sel = ADDR_BC;
            dec.cycles   = CYCLES_8;
         end
         CMD_LD_A_DE: begin
            dec.kind     = OP_READ;
            dec.addr_sel = ADDR_DE;
            dec.cycles   = CYCLES_8;
         end
         CMD_LD_A_HC: begin
            dec.kind     = OP_READ;
            dec.addr_sel = ADDR_HIGH_C;
            dec.cycles   = CYCLES_8;
         end
         CMD_LD_HC_A: begin
            dec.kind     = OP_WRITE;
            dec.addr_sel = ADDR_HIGH_C;
            dec.cycles   = CYCLES_8;
         end
         CMD_LD_A_HN: begin
            dec.kind     = OP_READ;
            dec.addr_sel = ADDR_HIGH_N;
            dec.cycles   = CYCLES_12;
         end
         CMD_LD_HN_A: begin
            dec.kind     = OP_WRITE;
            dec.addr_sel = ADDR_HIGH_N;
            dec.cycles   = CYCLES_12;
         end
         CMD_LD_A_NN: begin
            dec.kind     = OP_READ;
            dec.addr_sel = ADDR_NN;
            dec.cycles   = CYCLES_16;
         end
         CMD_LD_NN_A: begin
            dec.kind     = OP_WRITE;
            dec.addr_sel = ADDR_NN;
            dec.cycles   = CYCLES_16;
         end
         CMD_LD_A_HL_INC: begin
            dec.kind   = OP_READ;
            dec.hl_adj = HL_INC;
            dec.cycles = CYCLES_8;
         end
         CMD_LD_A_HL_DEC: begin
            dec.kind   = OP_READ;
            dec.hl_adj = HL_DEC;
            dec.cycles = CYCLES_8;
         end
         CMD_LD_BC_A: begin
            dec.kind     = OP_WRITE;
            dec.addr_sel = ADDR_BC;
            dec.cycles   = CYCLES_8;
         end
         CMD_LD_DE_A: begin
            dec.kind     = OP_WRITE;
            dec.addr_sel = ADDR_DE;
            dec.cycles   = CYCLES_8;
         end
         CMD_LD_HL_INC_A: begin
            dec.kind   = OP_WRITE;
            dec.hl_adj = HL_INC;
            dec.cycles = CYCLES_8;
         end
         CMD_LD_HL_DEC_A: begin
            dec.kind   = OP_WRITE;
            dec.hl_adj = HL_DEC;
            dec.cycles = CYCLES_8;
         end
         CMD_RETURN: begin
            dec.kind = OP_RETURN;
         end
         CMD_PRESET: begin
            dec.kind    = OP_REG_WRITE;
            dec.use_imm = 1'b1;
            dec.dest    = req_dest_reg;
         end
         default: begin
            dec.kind = OP_NONE;
         end
      endcase
   end

   // queue handshake
   assign req_full = (count_ff == QUEUE_FULL);
   assign push     = req_push && !req_full;
   assign op_valid = (count_ff != '0);
   assign pop      = op_valid && op_ready;
   assign op       = queue_ff[rd_ptr_ff];

   // queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

FILE: rtl/cpu8_ld_back.sv
// back end: register file, pending read tracking and response queue
`timescale 1ns / 1ps

module cpu8_ld_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 op_valid,
   input  cpu8_ld_pkg::op_type  op,
   output logic                 op_ready,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output cpu8_ld_pkg::rsp_type rsp
);
   import cpu8_ld_pkg::*;

   byte_type      rf_ff [REG_COUNT];
   logic          pending_ff, pending_in;
   reg_idx_type   pending_dest_ff, pending_dest_in;

   rsp_type       res;
   logic          exec;
   logic          rf_we;
   reg_idx_type   rf_widx;
   byte_type      rf_wval;
   logic          hl_we;
   addr_type      hl_new;

   addr_type      hl, bc, de;
   byte_type      n;
   byte_type      data;
   addr_type      addr;

   rsp_type       queue_ff [QUEUE_DEPTH];
   queue_ptr_type wr_ptr_ff, wr_ptr_in;
   queue_ptr_type rd_ptr_ff, rd_ptr_in;
   queue_cnt_type count_ff, count_in;
   logic          pop;

   // execute when the response queue has room
   assign op_ready = (count_ff != QUEUE_FULL);
   assign exec     = op_valid && op_ready;

   // operand formation
   assign hl   = {rf_ff[REG_H], rf_ff[REG_L]};
   assign bc   = {rf_ff[REG_B], rf_ff[REG_C]};
   assign de   = {rf_ff[REG_D], rf_ff[REG_E]};
   assign n    = op.imm[7:0];
   assign data = op.use_imm ? n : rf_ff[op.reg_sel];

   always_comb begin
      case (op.addr_sel)
         ADDR_HL:     addr = hl;
         ADDR_BC:     addr = bc;
         ADDR_DE:     addr = de;
         ADDR_HIGH_C: addr = {HIGH_PAGE, rf_ff[REG_C]};
         ADDR_HIGH_N: addr = {HIGH_PAGE, n};
         ADDR_NN:     addr = op.imm;
         default:     addr = hl;
      endcase
   end

   // hl post adjust, wraps at 16 bits
   always_comb begin
      case (op.hl_adj)
         HL_INC:  hl_new = hl + 16'd1;
         HL_DEC:  hl_new = hl - 16'd1;
         default: hl_new = hl;
      endcase
   end

   // response and state updates
   always_comb begin
      res             = '0;
      res.status      = STATUS_OK;
      pending_in      = pending_ff;
      pending_dest_in = pending_dest_ff;
      rf_we           = 1'b0;
      rf_widx         = op.dest;
      rf_wval         = data;
      hl_we           = 1'b0;
      if (op.kind == OP_RETURN) begin
         if (!pending_ff) begin
            res.status = STATUS_STRAY;
         end else begin
            pending_in          = 1'b0;
            rf_we               = 1'b1;
            rf_widx             = pending_dest_ff;
            rf_wval             = op.read_data;
            res.reg_write_valid = 1'b1;
            res.reg_write_index = pending_dest_ff;
            res.reg_write_value = op.read_data;
         end
      end else if (op.kind != OP_NONE) begin
         if (pending_ff) begin
            res.status = STATUS_BUSY;
         end else begin
            res.cycle_count = op.cycles;
            case (op.kind)
               OP_REG_WRITE: begin
                  rf_we               = 1'b1;
                  res.reg_write_valid = 1'b1;
                  res.reg_write_index = op.dest;
                  res.reg_write_value = data;
               end
               OP_READ: begin
                  res.bus_valid   = 1'b1;
                  res.bus_address = addr;
                  pending_in      = 1'b1;
                  pending_dest_in = op.dest;
                  hl_we           = (op.hl_adj != HL_KEEP);
               end
               OP_WRITE: begin
                  res.bus_valid      = 1'b1;
                  res.bus_write      = 1'b1;
                  res.bus_address    = addr;
                  res.bus_write_data = data;
                  hl_we              = (op.hl_adj != HL_KEEP);
               end
               default: begin
                  res.cycle_count = CYCLES_NONE;
               end
            endcase
         end
      end
   end

   // architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            rf_ff[i] <= '0;
         end
         pending_ff      <= 1'b0;
         pending_dest_ff <= '0;
      end else if (exec) begin
         pending_ff      <= pending_in;
         pending_dest_ff <= pending_dest_in;
         if (rf_we) begin
            rf_ff[rf_widx] <= rf_wval;
         end
         if (hl_we) begin
            rf_ff[REG_H] <= hl_new[15:8];
            rf_ff[REG_L] <= hl_new[7:0];
         end
      end
   end

   // response queue handshake
   assign rsp_empty = (count_ff == '0);
   assign pop       = rsp_pop && !rsp_empty;
   assign rsp       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (exec) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (exec && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !exec) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // response storage
   always_ff @(posedge clock) begin
      if (exec) begin
         queue_ff[wr_ptr_ff] <= res;
      end
   end

endmodule

FILE: sim/testbench.sv
// self-checking testbench for the 8-bit load unit
`timescale 1ns / 1ps

module testbench;
   import cpu8_ld_pkg::*;

   // request command codes
   typedef enum logic [4:0] {
      LD_R_R = 5'd0,
      LD_R_N,
      LD_R_HL,
      LD_HL_R,
      LD_HL_N,
      LD_A_BC,
      LD_A_DE,
      LD_A_HIGH_C,
      LD_HIGH_C_A,
      LD_A_HIGH_N,
      LD_HIGH_N_A,
      LD_A_NN,
      LD_NN_A,
      LD_A_HL_INC,
      LD_A_HL_DEC,
      LD_BC_A,
      LD_DE_A,
      LD_HL_INC_A,
      LD_HL_DEC_A,
      LD_DATA_RETURN,
      LD_PRESET,
      LD_UNUSED_FIRST,
      LD_UNUSED_LAST = 5'd31
   } ld_cmd_type;

   localparam int RANDOM_REQUESTS = 500;
   localparam int PAUSE_AT        = 250;
   localparam int STEADY_FIRST    = 300;
   localparam int STEADY_LAST     = 400;
   localparam int HOLD_AT         = 60;
   localparam int HOLD_CYCLES     = 80;
   localparam int DRAIN_CYCLES    = 10;
   localparam int IDLE_LIMIT      = 1000;
   localparam int IDLE_PERCENT    = 15;

   // register file shadow, pending read and predicted responses
   class load_result_board;
      byte_type    regs [REG_COUNT];
      logic        read_busy;
      reg_idx_type read_dest;
      rsp_type     predicted_responses [$];
      int          mismatches;
      int          results_checked;
      int          busy_seen;
      int          stray_seen;

      function new();
         foreach (regs[i]) regs[i] = '0;
         read_busy = 1'b0;
         read_dest = '0;
         mismatches = 0;
         results_checked = 0;
         busy_seen = 0;
         stray_seen = 0;
      endfunction

      function void load_reg(inout rsp_type r, input reg_idx_type idx, input byte_type v);
         regs[idx] = v;
         r.reg_write_valid = 1'b1;
         r.reg_write_index = idx;
         r.reg_write_value = v;
      endfunction

      function void bus_read(inout rsp_type r, input addr_type addr, input reg_idx_type dest,
                             input cycles_type cycles);
         r.bus_valid = 1'b1;
         r.bus_address = addr;
         r.cycle_count = cycles;
         read_busy = 1'b1;
         read_dest = dest;
      endfunction

      function void bus_write(inout rsp_type r, input addr_type addr, input byte_type data,
                              input cycles_type cycles);
         r.bus_valid = 1'b1;
         r.bus_write = 1'b1;
         r.bus_address = addr;
         r.bus_write_data = data;
         r.cycle_count = cycles;
      endfunction

      function void set_hl(addr_type v);
         regs[REG_H] = v[15:8];
         regs[REG_L] = v[7:0];
      endfunction

      // work out the response to one accepted request
      function void note_request(logic [4:0] cmd, reg_idx_type dst, reg_idx_type src,
                                 addr_type imm, byte_type rdata);
         rsp_type  r;
         addr_type hl;
         addr_type bc;
         addr_type de;
         byte_type n;
         byte_type a;
         r = '0;
         hl = {regs[REG_H], regs[REG_L]};
         bc = {regs[REG_B], regs[REG_C]};
         de = {regs[REG_D], regs[REG_E]};
         n = imm[7:0];
         a = regs[REG_A];
         if (cmd == LD_DATA_RETURN) begin
            if (!read_busy) begin
               r.status = STATUS_STRAY;
               stray_seen++;
            end else begin
               read_busy = 1'b0;
               load_reg(r, read_dest, rdata);
            end
         end else if (cmd > LD_PRESET) begin
            // unused command, all-zero response
         end else if (read_busy) begin
            r.status = STATUS_BUSY;
            busy_seen++;
         end else begin
            case (cmd)
               LD_R_R: begin
                  r.cycle_count = CYCLES_4;
                  load_reg(r, dst, regs[src]);
               end
               LD_R_N: begin
                  r.cycle_count = CYCLES_8;
                  load_reg(r, dst, n);
               end
               LD_R_HL:     bus_read(r, hl, dst, CYCLES_8);
               LD_HL_R:     bus_write(r, hl, regs[src], CYCLES_8);
               LD_HL_N:     bus_write(r, hl, n, CYCLES_12);
               LD_A_BC:     bus_read(r, bc, REG_A, CYCLES_8);
               LD_A_DE:     bus_read(r, de, REG_A, CYCLES_8);
               LD_A_HIGH_C: bus_read(r, {HIGH_PAGE, regs[REG_C]}, REG_A, CYCLES_8);
               LD_HIGH_C_A: bus_write(r, {HIGH_PAGE, regs[REG_C]}, a, CYCLES_8);
               LD_A_HIGH_N: bus_read(r, {HIGH_PAGE, n}, REG_A, CYCLES_12);
               LD_HIGH_N_A: bus_write(r, {HIGH_PAGE, n}, a, CYCLES_12);
               LD_A_NN:     bus_read(r, imm, REG_A, CYCLES_16);
               LD_NN_A:     bus_write(r, imm, a, CYCLES_16);
               LD_A_HL_INC: begin
                  bus_read(r, hl, REG_A, CYCLES_8);
                  set_hl(hl + 16'd1);
               end
               LD_A_HL_DEC: begin
                  bus_read(r, hl, REG_A, CYCLES_8);
                  set_hl(hl - 16'd1);
               end
               LD_BC_A:     bus_write(r, bc, a, CYCLES_8);
               LD_DE_A:     bus_write(r, de, a, CYCLES_8);
               LD_HL_INC_A: begin
                  bus_write(r, hl, a, CYCLES_8);
                  set_hl(hl + 16'd1);
               end
               LD_HL_DEC_A: begin
                  bus_write(r, hl, a, CYCLES_8);
                  set_hl(hl - 16'd1);
               end
               default:     load_reg(r, dst, n);
            endcase
         end
         predicted_responses.push_back(r);
      endfunction

      function void compare(string field, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            mismatches++;
         end
      endfunction

      // match one popped response against the oldest prediction
      function void check_result(rsp_type got);
         rsp_type want;
         results_checked++;
         if (predicted_responses.size() == 0) begin
            $display("%0t: response with nothing outstanding, expected none, got %h",
                     $time, got);
            mismatches++;
            return;
         end
         want = predicted_responses.pop_front();
         compare("bus_valid", 16'(want.bus_valid), 16'(got.bus_valid));
         compare("bus_write", 16'(want.bus_write), 16'(got.bus_write));
         compare("bus_address", want.bus_address, got.bus_address);
         compare("bus_write_data", 16'(want.bus_write_data), 16'(got.bus_write_data));
         compare("cycle_count", 16'(want.cycle_count), 16'(got.cycle_count));
         compare("reg_write_valid", 16'(want.reg_write_valid), 16'(got.reg_write_valid));
         compare("reg_write_index", 16'(want.reg_write_index), 16'(got.reg_write_index));
         compare("reg_write_value", 16'(want.reg_write_value), 16'(got.reg_write_value));
         compare("status", 16'(want.status), 16'(got.status));
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [4:0]  req_cmd = '0;
   logic [2:0]  req_dest_reg = '0;
   logic [2:0]  req_source_reg = '0;
   logic [15:0] req_immediate = '0;
   logic [7:0]  req_read_data = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic        rsp_bus_valid;
   logic        rsp_bus_write;
   logic [15:0] rsp_bus_address;
   logic [7:0]  rsp_bus_write_data;
   logic [4:0]  rsp_cycle_count;
   logic        rsp_reg_write_valid;
   logic [2:0]  rsp_reg_write_index;
   logic [7:0]  rsp_reg_write_value;
   logic [1:0]  rsp_status;

   load_result_board board;
   bit steady_flow = 1'b0;
   int requests_sent = 0;
   int full_stall_cycles = 0;

   cpu_8bit_load_unit uut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_cmd             (req_cmd),
      .req_dest_reg        (req_dest_reg),
      .req_source_reg      (req_source_reg),
      .req_immediate       (req_immediate),
      .req_read_data       (req_read_data),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_bus_valid       (rsp_bus_valid),
      .rsp_bus_write       (rsp_bus_write),
      .rsp_bus_address     (rsp_bus_address),
      .rsp_bus_write_data  (rsp_bus_write_data),
      .rsp_cycle_count     (rsp_cycle_count),
      .rsp_reg_write_valid (rsp_reg_write_valid),
      .rsp_reg_write_index (rsp_reg_write_index),
      .rsp_reg_write_value (rsp_reg_write_value),
      .rsp_status          (rsp_status)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // offer one request, with random idle cycles ahead of it, until accepted
   task automatic send_request(input logic [4:0] cmd, input reg_idx_type dst,
                               input reg_idx_type src, input addr_type imm,
                               input byte_type rdata);
      while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_cmd <= cmd;
      req_dest_reg <= dst;
      req_source_reg <= src;
      req_immediate <= imm;
      req_read_data <= rdata;
      @(posedge clock);
      while (req_full) begin
         full_stall_cycles++;
         @(posedge clock);
      end
      board.note_request(cmd, dst, src, imm, rdata);
      requests_sent++;
   endtask

   // hold the request side until every predicted response has been popped
   task automatic wait_for_drain();
      req_push <= 1'b0;
      while (board.predicted_responses.size() != 0) @(posedge clock);
   endtask

   // edge cases first, then each load form once, reads followed by their return
   task automatic run_directed();
      int k;
      send_request(LD_DATA_RETURN, REG_B, REG_B, 16'h0000, 8'h00);
      send_request(LD_UNUSED_LAST, REG_A, REG_A, 16'hffff, 8'hff);
      send_request(LD_PRESET, REG_H, REG_B, 16'h00ff, 8'h00);
      send_request(LD_PRESET, REG_L, REG_B, 16'hffff, 8'h00);
      send_request(LD_PRESET, REG_A, REG_B, 16'ha55a, 8'h00);
      // hl wraps up from ffff, then back down from 0000
      send_request(LD_HL_INC_A, REG_B, REG_B, 16'h0000, 8'h00);
      send_request(LD_HL_DEC_A, REG_B, REG_B, 16'h0000, 8'h00);
      for (k = LD_R_R; k <= LD_DE_A; k++) begin
         send_request(5'(k), reg_idx_type'($urandom_range(7)),
                      reg_idx_type'($urandom_range(7)), 16'($urandom_range(65535)),
                      8'($urandom_range(255)));
         if (board.read_busy) begin
            // a load and a preset arriving while the read is still open
            if (k == LD_R_HL) begin
               send_request(LD_R_N, REG_A, REG_B, 16'hffff, 8'h00);
               send_request(LD_PRESET, REG_C, REG_B, 16'h0001, 8'h00);
            end
            send_request(LD_DATA_RETURN, REG_B, REG_B, 16'h0000, (k % 2) ? 8'hff : 8'h00);
         end
      end
   endtask

   // mostly well-formed read/return pairs with random content, some noise
   task automatic run_random();
      int counted;
      int roll;
      logic [4:0] cmd;
      counted = 0;
      while (counted < RANDOM_REQUESTS) begin
         steady_flow = (counted >= STEADY_FIRST && counted < STEADY_LAST);
         if (counted == PAUSE_AT) wait_for_drain();
         roll = $urandom_range(99);
         if (board.read_busy) begin
            if (roll < 85) cmd = LD_DATA_RETURN;
            else cmd = 5'($urandom_range(LD_PRESET));
            if (cmd == LD_DATA_RETURN && roll >= 85) cmd = LD_PRESET;
         end else if (roll < 4) begin
            cmd = LD_DATA_RETURN;
         end else if (roll < 8) begin
            cmd = 5'($urandom_range(LD_UNUSED_LAST, LD_UNUSED_FIRST));
         end else if (roll < 22) begin
            cmd = LD_PRESET;
         end else begin
            cmd = 5'($urandom_range(LD_HL_DEC_A));
         end
         send_request(cmd, reg_idx_type'($urandom_range(7)), reg_idx_type'($urandom_range(7)),
                      16'($urandom_range(65535)), 8'($urandom_range(255)));
         if (cmd <= LD_PRESET) counted++;
      end
      steady_flow = 1'b0;
   endtask

   // response side: random pops, one long hold-off, check every popped response
   initial begin : response_side
      rsp_type got;
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            got.bus_valid = rsp_bus_valid;
            got.bus_write = rsp_bus_write;
            got.bus_address = rsp_bus_address;
            got.bus_write_data = rsp_bus_write_data;
            got.cycle_count = rsp_cycle_count;
            got.reg_write_valid = rsp_reg_write_valid;
            got.reg_write_index = rsp_reg_write_index;
            got.reg_write_value = rsp_reg_write_value;
            got.status = status_type'(rsp_status);
            board.check_result(got);
            if (board.results_checked == HOLD_AT) hold_left = HOLD_CYCLES;
         end
         if (reset || hold_left > 0) begin
            rsp_pop <= 1'b0;
            if (hold_left > 0) hold_left--;
         end else begin
            rsp_pop <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("** cpu_8bit_load_unit: FAILED **");
      $finish;
   end

   // main sequence
   initial begin : stimulus
      board = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d requests sent, %0d responses checked, %0d mismatches", requests_sent,
               board.results_checked, board.mismatches);
      $display("%0d busy rejections, %0d stray returns, %0d cycles stalled on full",
               board.busy_seen, board.stray_seen, full_stall_cycles);
      if (board.mismatches == 0) begin
         $display("** cpu_8bit_load_unit: PASSED **");
      end else begin
         $display("** cpu_8bit_load_unit: FAILED **");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/cpu8_ld_pkg.sv
rtl/cpu8_ld_front.sv
rtl/cpu8_ld_back.sv
rtl/cpu_8bit_load_unit.sv
sim/testbench.sv
